### hw/rtl/rdf_pkg.sv
// rdf_pkg: shared constants, types and lookup functions for the radix digit formatter.
// No dependencies; every other file in hw/rtl imports it.
`timescale 1ns / 1ps

package rdf_pkg;

	// Digit count limit: the position field cannot address more than 32 digits
	localparam int MAX_DIGITS  = 32;
	localparam int DIGIT_LIMIT = (MAX_DIGITS < 32) ? MAX_DIGITS : 32;

	// Field widths
	localparam int VALUE_W     = 32;
	localparam int CHAR_W      = 7;
	localparam int POS_W       = 5;
	localparam int DIGIT_W     = 6;
	localparam int SHIFT_W     = 3;
	localparam int CFG_DATA_W  = 6;
	localparam int CFG_INDEX_W = 2;

	// Radix and count limits / reset values
	localparam logic [DIGIT_W-1:0]    BASE_MIN    = 6'd2;
	localparam logic [DIGIT_W-1:0]    BASE_MAX    = 6'd36;
	localparam logic [DIGIT_W-1:0]    BASE_RESET  = 6'd10;
	localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 6'd10;

	// ASCII mapping
	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0]  ALPHA_GAP  = 7'd7;
	localparam logic [DIGIT_W-1:0] DEC_MAX    = 6'd9;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RADIX       = 2'd0,
		REG_DIGIT_COUNT = 2'd1
	} cfg_reg_t;

	// Reciprocal table: m = floor(2^(32+l)/d) + 1 with l = ceil(log2 d).
	// m lies in (2^32, 2^33); only the low 32 bits are stored, bit 32 is implied.
	localparam logic [31:0] RECIP_LO [0:36] = '{
		32'd0,
		32'd0,
		32'(((64'd1 << 33) / 64'd2)  + 64'd1),
		32'(((64'd1 << 34) / 64'd3)  + 64'd1),
		32'(((64'd1 << 34) / 64'd4)  + 64'd1),
		32'(((64'd1 << 35) / 64'd5)  + 64'd1),
		32'(((64'd1 << 35) / 64'd6)  + 64'd1),
		32'(((64'd1 << 35) / 64'd7)  + 64'd1),
		32'(((64'd1 << 35) / 64'd8)  + 64'd1),
		32'(((64'd1 << 36) / 64'd9)  + 64'd1),
		32'(((64'd1 << 36) / 64'd10) + 64'd1),
		32'(((64'd1 << 36) / 64'd11) + 64'd1),
		32'(((64'd1 << 36) / 64'd12) + 64'd1),
		32'(((64'd1 << 36) / 64'd13) + 64'd1),
		32'(((64'd1 << 36) / 64'd14) + 64'd1),
		32'(((64'd1 << 36) / 64'd15) + 64'd1),
		32'(((64'd1 << 36) / 64'd16) + 64'd1),
		32'(((64'd1 << 37) / 64'd17) + 64'd1),
		32'(((64'd1 << 37) / 64'd18) + 64'd1),
		32'(((64'd1 << 37) / 64'd19) + 64'd1),
		32'(((64'd1 << 37) / 64'd20) + 64'd1),
		32'(((64'd1 << 37) / 64'd21) + 64'd1),
		32'(((64'd1 << 37) / 64'd22) + 64'd1),
		32'(((64'd1 << 37) / 64'd23) + 64'd1),
		32'(((64'd1 << 37) / 64'd24) + 64'd1),
		32'(((64'd1 << 37) / 64'd25) + 64'd1),
		32'(((64'd1 << 37) / 64'd26) + 64'd1),
		32'(((64'd1 << 37) / 64'd27) + 64'd1),
		32'(((64'd1 << 37) / 64'd28) + 64'd1),
		32'(((64'd1 << 37) / 64'd29) + 64'd1),
		32'(((64'd1 << 37) / 64'd30) + 64'd1),
		32'(((64'd1 << 37) / 64'd31) + 64'd1),
		32'(((64'd1 << 37) / 64'd32) + 64'd1),
		32'(((64'd1 << 38) / 64'd33) + 64'd1),
		32'(((64'd1 << 38) / 64'd34) + 64'd1),
		32'(((64'd1 << 38) / 64'd35) + 64'd1),
		32'(((64'd1 << 38) / 64'd36) + 64'd1)
	};

	// Active configuration seen by the datapath
	typedef struct packed {
		logic [DIGIT_W-1:0]    base;
		logic [SHIFT_W-1:0]    shift;
		logic [31:0]           recip_lo;
		logic [CFG_DATA_W-1:0] count;
	} fmt_cfg_t;

	// One digit request from the divider loop to the digit pipeline
	typedef struct packed {
		logic [DIGIT_W-1:0] q_lo;
		logic [DIGIT_W-1:0] qn_lo;
		logic               neg;
		logic [POS_W-1:0]   pos;
		logic               is_last;
	} digit_req_t;

	// Out-of-range radix values saturate to 2 or 36
	function automatic logic [DIGIT_W-1:0] clamp_base(input logic [CFG_DATA_W-1:0] raw);
		logic [DIGIT_W-1:0] b;
		b = raw;
		if (raw < BASE_MIN)
			b = BASE_MIN;
		else if (raw > BASE_MAX)
			b = BASE_MAX;
		return b;
	endfunction

	// Digit count saturates at the limit
	function automatic logic [CFG_DATA_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] raw);
		logic [CFG_DATA_W-1:0] c;
		c = raw;
		if (raw > CFG_DATA_W'(DIGIT_LIMIT))
			c = CFG_DATA_W'(DIGIT_LIMIT);
		return c;
	endfunction

	// l = ceil(log2 base) for base in 2..36
	function automatic logic [SHIFT_W-1:0] base_shift(input logic [DIGIT_W-1:0] base);
		logic [SHIFT_W-1:0] s;
		if (base <= 6'd2)
			s = 3'd1;
		else if (base <= 6'd4)
			s = 3'd2;
		else if (base <= 6'd8)
			s = 3'd3;
		else if (base <= 6'd16)
			s = 3'd4;
		else if (base <= 6'd32)
			s = 3'd5;
		else
			s = 3'd6;
		return s;
	endfunction

endpackage

### hw/rtl/rdf_in_if.sv
// rdf_in_if: input channel carrying one signed value per transfer.
// Depends on rdf_pkg for the field width.
`timescale 1ns / 1ps

interface rdf_in_if import rdf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

### hw/rtl/rdf_out_if.sv
// rdf_out_if: output channel carrying one ASCII digit and its position per transfer.
// Depends on rdf_pkg for the field widths.
`timescale 1ns / 1ps

interface rdf_out_if import rdf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic [POS_W-1:0]  position;
	logic              is_last;

	modport source (output valid, output digit_char, output position, output is_last,
		input ready);
	modport sink   (input valid, input digit_char, input position, input is_last,
		output ready);
endinterface

### hw/rtl/rdf_cfg_if.sv
// rdf_cfg_if: register write channel (index and data per transfer).
// Depends on rdf_pkg for the field widths.
`timescale 1ns / 1ps

interface rdf_cfg_if import rdf_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/radix_digit_formatter.sv
// radix_digit_formatter: signed value to ASCII digits in a configured radix, LSD first.
// Each value's transfer loads the reciprocal-multiply quotient loop, whose digit requests pass
// the capture, remainder and ASCII output stages; digits are offered one per cycle unless the
// output stalls, digit_count digits per value; the next value is taken as the last digit issues.
// Reset: radix and digit count return to 10, all pipeline valid bits clear.
`timescale 1ns / 1ps

module radix_digit_formatter import rdf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rdf_cfg_if.sink   cfg,
	rdf_in_if.sink    item,
	rdf_out_if.source digit
);

	fmt_cfg_t   fmt;
	logic       req_valid;
	logic       req_ready;
	digit_req_t req;

	// Configuration registers
	rdf_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fmt    (fmt)
	);

	// Quotient loop
	rdf_issue u_issue (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.fmt       (fmt),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready)
	);

	// Digit pipeline and output register
	rdf_digit_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.fmt       (fmt),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.digit     (digit)
	);

endmodule

### hw/rtl/rdf_cfg.sv
// rdf_cfg: configuration registers; clamps radix/count and looks up the reciprocal.
// Depends on rdf_pkg and rdf_cfg_if.
`timescale 1ns / 1ps

module rdf_cfg import rdf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	rdf_cfg_if.sink  cfg,
	output fmt_cfg_t fmt
);

	logic [DIGIT_W-1:0]    base_q;
	logic [SHIFT_W-1:0]    shift_q;
	logic [31:0]           recip_q;
	logic [CFG_DATA_W-1:0] count_q;
	logic [DIGIT_W-1:0]    base_new;

	// Writes are always accepted; ready is tied high
	assign cfg.ready = 1'b1;

	assign base_new = clamp_base(cfg.data);

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RESET;
			shift_q <= base_shift(BASE_RESET);
			recip_q <= RECIP_LO[BASE_RESET];
			count_q <= COUNT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_RADIX: begin
					base_q  <= base_new;
					shift_q <= base_shift(base_new);
					recip_q <= RECIP_LO[base_new];
				end
				REG_DIGIT_COUNT: begin
					count_q <= clamp_count(cfg.data);
				end
				default: begin
				end
			endcase
		end
	end

	assign fmt = '{base: base_q, shift: shift_q, recip_lo: recip_q, count: count_q};

endmodule

### hw/rtl/rdf_issue.sv
// rdf_issue: takes values in and runs the quotient loop, one reciprocal division per digit.
// Depends on rdf_pkg and rdf_in_if.
`timescale 1ns / 1ps

module rdf_issue import rdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rdf_in_if.sink     item,
	input  fmt_cfg_t   fmt,
	output logic       req_valid,
	output digit_req_t req,
	input  logic       req_ready
);

	logic               busy_q;
	logic [VALUE_W-1:0] quot_q;
	logic               neg_q;
	logic [POS_W-1:0]   pos_q;

	logic               issue;
	logic               issue_last;
	logic               accept;
	logic [63:0]        prod;
	logic [64:0]        wide;
	logic [VALUE_W-1:0] quot_next;

	// Handshake: next value may be taken while the last digit goes out
	assign issue      = busy_q && req_ready;
	assign issue_last = issue && (pos_q == '0);
	assign item.ready = !busy_q || issue_last;
	assign accept     = item.valid && item.ready;

	// quot / base = (quot * (2^32 + recip_lo)) >> (32 + l)
	always_comb begin
		prod      = 64'(quot_q) * 64'(fmt.recip_lo);
		wide      = {1'b0, quot_q, 32'd0} + {1'b0, prod};
		quot_next = VALUE_W'(wide >> (7'd32 + 7'(fmt.shift)));
	end

	// Digit request: low bits are enough to rebuild the remainder downstream
	assign req_valid = busy_q;
	assign req = '{q_lo: quot_q[DIGIT_W-1:0], qn_lo: quot_next[DIGIT_W-1:0], neg: neg_q,
		pos: pos_q, is_last: (pos_q == '0)};

	// Quotient loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			quot_q <= '0;
			neg_q  <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (issue) begin
				quot_q <= quot_next;
				pos_q  <= pos_q - 5'd1;
				if (issue_last)
					busy_q <= 1'b0;
			end
			// zero digit count: value is taken and dropped, state kept
			if (accept && (fmt.count != '0)) begin
				busy_q <= 1'b1;
				neg_q  <= item.value[VALUE_W-1];
				quot_q <= item.value[VALUE_W-1] ? ~item.value : item.value;
				pos_q  <= POS_W'(fmt.count - 6'd1);
			end
		end
	end

	// A new value starts at the highest position index, digit count minus one
	a_load_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (fmt.count != '0)) |=> (busy_q && (pos_q == POS_W'($past(fmt.count) - 6'd1))))
		else $error("position not loaded from digit count");

	// Each issued digit that is not the last steps the position down by one
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && (pos_q != '0)) |=> (busy_q && (pos_q == $past(pos_q) - 5'd1)))
		else $error("position did not step down");

	// The loop goes idle after the leftmost digit unless a new value arrives
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(issue_last && !(item.valid && (fmt.count != '0))) |=> !busy_q)
		else $error("loop still busy after last digit");

endmodule

### hw/rtl/rdf_digit_pipe.sv
// rdf_digit_pipe: three-stage digit pipeline (capture, remainder/complement, ASCII output).
// Depends on rdf_pkg and rdf_out_if.
`timescale 1ns / 1ps

module rdf_digit_pipe import rdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  fmt_cfg_t   fmt,
	input  logic       req_valid,
	input  digit_req_t req,
	output logic       req_ready,
	rdf_out_if.source  digit
);

	logic               valid_s1;
	digit_req_t         req_s1;
	logic               valid_s2;
	logic [DIGIT_W-1:0] digit_s2;
	logic [POS_W-1:0]   pos_s2;
	logic               last_s2;
	logic               valid_s3;
	logic [CHAR_W-1:0]  char_s3;
	logic [POS_W-1:0]   pos_s3;
	logic               last_s3;

	logic               ready_s1;
	logic               ready_s2;
	logic               ready_s3;
	logic [DIGIT_W-1:0] rem;
	logic [DIGIT_W-1:0] digit_val;
	logic [CHAR_W-1:0]  char_val;

	// Per-stage flow control: a stage moves when empty or when the next one moves
	assign ready_s3  = !valid_s3 || digit.ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign req_ready = ready_s1;

	// Remainder mod 64 is exact since it stays below the base
	always_comb begin
		rem       = req_s1.q_lo - DIGIT_W'(req_s1.qn_lo * fmt.base);
		digit_val = req_s1.neg ? (fmt.base - 6'd1 - rem) : rem;
	end

	// Letters start right after '9' plus the punctuation gap
	always_comb begin
		char_val = ASCII_ZERO + CHAR_W'(digit_s2);
		if (digit_s2 > DEC_MAX)
			char_val = char_val + ALPHA_GAP;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= req_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_s3)
				valid_s3 <= valid_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (ready_s1 && req_valid)
			req_s1 <= req;
		if (ready_s2 && valid_s1) begin
			digit_s2 <= digit_val;
			pos_s2   <= req_s1.pos;
			last_s2  <= req_s1.is_last;
		end
		if (ready_s3 && valid_s2) begin
			char_s3 <= char_val;
			pos_s3  <= pos_s2;
			last_s3 <= last_s2;
		end
	end

	assign digit.valid      = valid_s3;
	assign digit.digit_char = char_s3;
	assign digit.position   = pos_s3;
	assign digit.is_last    = last_s3;

endmodule
